// File: hdl/mpeq_pkg.sv
package mpeq_pkg;

  // Field and datapath widths
  localparam int MaxSemiAxisDef = 1023;
  localparam int CoordW = 12;               // origin coordinates
  localparam int PixW   = 13;               // pixel coordinates
  localparam int AxisW  = 10;               // semi-axes and y
  localparam int SatW   = 12;               // width of the saturation bound
  localparam int XW     = 12;               // x, at most one increment per step
  localparam int StepW  = 12;               // step counter and limit
  localparam int ColorW = 32;
  localparam int SqrW   = 20;               // a*a and b*b
  localparam int SqW    = 27;               // (2x+1)^2 and (y-1)^2
  localparam int LinW   = 15;               // small linear terms in x and y
  localparam int MulAW  = 28;
  localparam int MulBW  = 21;
  localparam int DecW   = 48;               // decision variable and accumulator
  localparam int UAddrW = 5;

  // Command codes
  localparam logic CMD_START = 1'b0;

  // Microcode addresses
  localparam logic [UAddrW-1:0] UA_S0    = 5'd0;
  localparam logic [UAddrW-1:0] UA_S1    = 5'd1;
  localparam logic [UAddrW-1:0] UA_S2    = 5'd2;
  localparam logic [UAddrW-1:0] UA_S3    = 5'd3;
  localparam logic [UAddrW-1:0] UA_E1    = 5'd4;
  localparam logic [UAddrW-1:0] UA_P0    = 5'd5;
  localparam logic [UAddrW-1:0] UA_P1    = 5'd6;
  localparam logic [UAddrW-1:0] UA_P2    = 5'd7;
  localparam logic [UAddrW-1:0] UA_P3    = 5'd8;
  localparam logic [UAddrW-1:0] UA_P4    = 5'd9;
  localparam logic [UAddrW-1:0] UA_P5    = 5'd10;
  localparam logic [UAddrW-1:0] UA_SW0   = 5'd11;
  localparam logic [UAddrW-1:0] UA_SW1   = 5'd12;
  localparam logic [UAddrW-1:0] UA_SW2   = 5'd13;
  localparam logic [UAddrW-1:0] UA_SW3   = 5'd14;
  localparam logic [UAddrW-1:0] UA_SW4   = 5'd15;
  localparam logic [UAddrW-1:0] UA_SW5   = 5'd16;
  localparam logic [UAddrW-1:0] UA_R2    = 5'd17;
  localparam logic [UAddrW-1:0] UA_R2P   = 5'd18;
  localparam logic [UAddrW-1:0] UA_R2N   = 5'd19;
  localparam logic [UAddrW-1:0] UA_R2N1  = 5'd20;
  localparam logic [UAddrW-1:0] UA_FIN   = 5'd21;
  localparam logic [UAddrW-1:0] UA_M0    = 5'd22;
  localparam logic [UAddrW-1:0] UA_M1    = 5'd23;
  localparam logic [UAddrW-1:0] UA_M2    = 5'd24;
  localparam logic [UAddrW-1:0] UA_M3    = 5'd25;

  // Control word fields
  typedef enum logic [1:0] {SEQ_NEXT, SEQ_BRANCH, SEQ_EMIT} seq_e;
  typedef enum logic [2:0] {C_ALWAYS, C_REGION, C_ACC_LE0, C_DEC_NEG, C_SINGLE} cond_e;
  typedef enum logic [1:0] {MA_LIN, MA_A2, MA_B2, MA_SQ} mula_e;
  typedef enum logic [1:0] {MB_LIN, MB_A2, MB_B2} mulb_e;
  typedef enum logic [3:0] {
    L_A, L_B, L_2X_P1, L_2X_P2, L_2X_P3, L_Y_M1, L_2Y_M1, L_2_M2Y, L_3_M2Y
  } lin_e;
  typedef enum logic [1:0] {LD_NONE, LD_A2, LD_B2, LD_SQ} ld_e;
  typedef enum logic {DST_DEC, DST_ACC} dst_e;
  typedef enum logic [1:0] {ALU_NONE, ALU_LOAD, ALU_ADD, ALU_SUB} aluop_e;
  typedef enum logic [1:0] {Q_PP, Q_PM, Q_MM, Q_MP} quad_e;

  typedef struct packed {
    seq_e              seq;
    cond_e             cond;
    logic [UAddrW-1:0] target;
    logic              mul_en;
    mula_e             mul_a;
    mulb_e             mul_b;
    lin_e              lin;
    ld_e               ld;
    dst_e              dst;
    aluop_e            alu;
    logic              sh2;
    logic              x_inc;
    logic              y_dec;
    logic              set_region;
    logic              fin;
    quad_e             quad;
    logic              last;
  } ctrl_t;

  localparam ctrl_t UcNop = '{
    seq: SEQ_NEXT, cond: C_ALWAYS, target: UA_S0, mul_en: 1'b0, mul_a: MA_LIN,
    mul_b: MB_LIN, lin: L_A, ld: LD_NONE, dst: DST_DEC, alu: ALU_NONE, sh2: 1'b0,
    x_inc: 1'b0, y_dec: 1'b0, set_region: 1'b0, fin: 1'b0, quad: Q_PP, last: 1'b0
  };

  // Microprogram. A product issued in one step is in prod_q for the next.
  function automatic ctrl_t ucode(input logic [UAddrW-1:0] addr);
    ctrl_t w;
    w = UcNop;
    case (addr)
      // start: d = a^2 + 4b^2 - 4a^2 b
      UA_S0: begin
        w.mul_en = 1'b1; w.lin = L_A;
      end
      UA_S1: begin
        w.ld = LD_A2; w.alu = ALU_LOAD;
        w.mul_en = 1'b1; w.lin = L_B;
      end
      UA_S2: begin
        w.ld = LD_B2; w.alu = ALU_ADD; w.sh2 = 1'b1;
        w.mul_en = 1'b1; w.mul_a = MA_A2; w.lin = L_B;
      end
      UA_S3: begin
        w.alu = ALU_SUB; w.sh2 = 1'b1;
      end
      UA_E1: begin
        w.seq = SEQ_EMIT; w.quad = Q_PP; w.last = 1'b1;
      end
      // region one test: a^2(2y-1) - b^2(2x+2) > 0
      UA_P0: begin
        w.seq = SEQ_BRANCH; w.cond = C_REGION; w.target = UA_R2;
        w.mul_en = 1'b1; w.mul_a = MA_A2; w.lin = L_2Y_M1;
      end
      UA_P1: begin
        w.dst = DST_ACC; w.alu = ALU_LOAD;
        w.mul_en = 1'b1; w.mul_a = MA_B2; w.lin = L_2X_P2;
      end
      UA_P2: begin
        w.dst = DST_ACC; w.alu = ALU_SUB;
        w.mul_en = 1'b1; w.mul_a = MA_B2; w.lin = L_2X_P3;
      end
      UA_P3: begin
        w.seq = SEQ_BRANCH; w.cond = C_ACC_LE0; w.target = UA_SW0;
      end
      // region one update
      UA_P4: begin
        w.seq = SEQ_BRANCH; w.cond = C_DEC_NEG; w.target = UA_FIN;
        w.alu = ALU_ADD; w.sh2 = 1'b1; w.x_inc = 1'b1;
        w.mul_en = 1'b1; w.mul_a = MA_A2; w.lin = L_2_M2Y;
      end
      UA_P5: begin
        w.seq = SEQ_BRANCH; w.cond = C_ALWAYS; w.target = UA_FIN;
        w.alu = ALU_ADD; w.sh2 = 1'b1; w.y_dec = 1'b1;
      end
      // switch to region two: d = b^2(2x+1)^2 + 4a^2(y-1)^2 - 4a^2 b^2
      UA_SW0: begin
        w.set_region = 1'b1; w.mul_en = 1'b1; w.lin = L_2X_P1;
      end
      UA_SW1: begin
        w.ld = LD_SQ; w.mul_en = 1'b1; w.lin = L_Y_M1;
      end
      UA_SW2: begin
        w.ld = LD_SQ; w.mul_en = 1'b1; w.mul_a = MA_SQ; w.mul_b = MB_B2;
      end
      UA_SW3: begin
        w.alu = ALU_LOAD; w.mul_en = 1'b1; w.mul_a = MA_SQ; w.mul_b = MB_A2;
      end
      UA_SW4: begin
        w.alu = ALU_ADD; w.sh2 = 1'b1;
        w.mul_en = 1'b1; w.mul_a = MA_A2; w.mul_b = MB_B2;
      end
      UA_SW5: begin
        w.alu = ALU_SUB; w.sh2 = 1'b1;
      end
      // region two step
      UA_R2: begin
        w.seq = SEQ_BRANCH; w.cond = C_DEC_NEG; w.target = UA_R2N;
        w.mul_en = 1'b1; w.mul_a = MA_A2; w.lin = L_3_M2Y;
      end
      UA_R2P: begin
        w.seq = SEQ_BRANCH; w.cond = C_ALWAYS; w.target = UA_FIN;
        w.alu = ALU_ADD; w.sh2 = 1'b1; w.y_dec = 1'b1;
      end
      UA_R2N: begin
        w.alu = ALU_ADD; w.sh2 = 1'b1;
        w.mul_en = 1'b1; w.mul_a = MA_B2; w.lin = L_2X_P2;
      end
      UA_R2N1: begin
        w.alu = ALU_ADD; w.sh2 = 1'b1; w.x_inc = 1'b1; w.y_dec = 1'b1;
      end
      // step count, end test, then one or four points
      UA_FIN: begin
        w.seq = SEQ_BRANCH; w.cond = C_SINGLE; w.target = UA_E1; w.fin = 1'b1;
      end
      UA_M0: begin
        w.seq = SEQ_EMIT; w.quad = Q_PP;
      end
      UA_M1: begin
        w.seq = SEQ_EMIT; w.quad = Q_PM;
      end
      UA_M2: begin
        w.seq = SEQ_EMIT; w.quad = Q_MM;
      end
      UA_M3: begin
        w.seq = SEQ_EMIT; w.quad = Q_MP; w.last = 1'b1;
      end
      default: w = UcNop;
    endcase
    return w;
  endfunction

endpackage

// File: hdl/midpoint_ellipse_quadrant_core.sv
// Midpoint ellipse quadrant point generator.
// Input channel (in_valid_i / in_stall_o): a start beat (command 0) loads the
// origin, semi-axes, step limit, mirror flag and colour and yields one pixel,
// the origin. A step beat (command 1) advances the two-region midpoint
// algorithm by one iteration and yields one pixel, or four mirrored pixels.
// A step beat with no shape in progress yields nothing.
// Output channel (out_valid_o / out_stall_i): one pixel per beat, with
// last_of_group on the final pixel of the input beat and shape_done on the
// final pixel of the ellipse.
// A single shared 28x21 multiplier, sequenced by a microcode table, forms every
// product, so a beat takes longer the more products it needs: the step beat
// that changes region is the longest, and mirror mode emits four pixels in
// place of one.
// One beat is taken at a time; in_stall_o is high while one is being worked.
// The last pixel sits in an output register, so the next beat is accepted
// while it waits. When the receiver stalls, emission steps hold until the
// output register frees up. Reset clears the sequencer, the region flag, the
// output valid flag and the shape-in-progress flag.
module midpoint_ellipse_quadrant_core import mpeq_pkg::*; #(
  parameter int MAX_SEMI_AXIS = MaxSemiAxisDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic                     command_i,
  input  logic signed [CoordW-1:0] center_x_i,
  input  logic signed [CoordW-1:0] center_y_i,
  input  logic        [AxisW-1:0]  semi_a_i,
  input  logic        [AxisW-1:0]  semi_b_i,
  input  logic        [StepW-1:0]  step_limit_i,
  input  logic                     mirror_i,
  input  logic        [ColorW-1:0] color_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [PixW-1:0]   pixel_x_o,
  output logic signed [PixW-1:0]   pixel_y_o,
  output logic        [ColorW-1:0] pixel_color_o,
  output logic                     last_of_group_o,
  output logic                     shape_done_o
);

  localparam logic [SatW-1:0] MaxAxis = SatW'(MAX_SEMI_AXIS);

  // Control state
  logic              busy_q, busy_d;
  logic [UAddrW-1:0] upc_q, upc_d;
  logic              active_q, active_d;
  logic              region_q, region_d;
  logic              out_valid_q, out_valid_d;

  // Shape state and datapath
  logic signed [CoordW-1:0] origin_x_q, origin_x_d, origin_y_q, origin_y_d;
  logic [AxisW-1:0]         axis_a_q, axis_a_d, axis_b_q, axis_b_d;
  logic [XW-1:0]            x_q, x_d;
  logic [AxisW-1:0]         y_q, y_d;
  logic [StepW-1:0]         steps_q, steps_d, limit_q, limit_d;
  logic                     mirror_q, mirror_d;
  logic [ColorW-1:0]        color_q, color_d;
  logic [SqrW-1:0]          a2_q, a2_d, b2_q, b2_d;
  logic [SqW-1:0]           sq_q, sq_d;
  logic signed [DecW-1:0]   prod_q, prod_d, dec_q, dec_d, acc_q, acc_d;

  // Output register
  logic signed [PixW-1:0]   px_q, px_d, py_q, py_d;
  logic [ColorW-1:0]        pcol_q, pcol_d;
  logic                     last_q, last_d, done_q, done_d;

  ctrl_t                         uc;
  logic                          in_accept, is_start, slot_free, emit_fire, cond_true;
  logic [AxisW-1:0]              a_sat, b_sat;
  logic signed [LinW-1:0]        xs, ys, lin;
  logic signed [MulAW-1:0]       mul_a;
  logic signed [MulBW-1:0]       mul_b;
  logic signed [MulAW+MulBW-1:0] mul_full;
  logic signed [DecW-1:0]        p_sh, alu_base, alu_res;
  logic [StepW-1:0]              steps_inc;
  logic signed [PixW-1:0]        ox, oy, dx, dy, px, py;

  assign uc = ucode(upc_q);

  // Handshakes
  assign in_stall_o = busy_q;
  assign in_accept  = in_valid_i & ~busy_q;
  assign is_start   = command_i == CMD_START;
  assign slot_free  = ~out_valid_q | ~out_stall_i;
  assign emit_fire  = busy_q & (uc.seq == SEQ_EMIT) & slot_free;

  // Semi-axis saturation
  assign a_sat = (SatW'(semi_a_i) > MaxAxis) ? MaxAxis[AxisW-1:0] : semi_a_i;
  assign b_sat = (SatW'(semi_b_i) > MaxAxis) ? MaxAxis[AxisW-1:0] : semi_b_i;

  // Branch condition
  always_comb begin
    case (uc.cond)
      C_ALWAYS:  cond_true = 1'b1;
      C_REGION:  cond_true = region_q;
      C_ACC_LE0: cond_true = acc_q[DecW-1] | (acc_q == '0);
      C_DEC_NEG: cond_true = dec_q[DecW-1];
      C_SINGLE:  cond_true = ~mirror_q;
      default:   cond_true = 1'b0;
    endcase
  end

  // Linear term generator
  assign xs = signed'(LinW'(x_q));
  assign ys = signed'(LinW'(y_q));

  always_comb begin
    case (uc.lin)
      L_A:     lin = signed'(LinW'(axis_a_q));
      L_B:     lin = signed'(LinW'(axis_b_q));
      L_2X_P1: lin = LinW'(2 * xs + 1);
      L_2X_P2: lin = LinW'(2 * xs + 2);
      L_2X_P3: lin = LinW'(2 * xs + 3);
      L_Y_M1:  lin = LinW'(ys - 1);
      L_2Y_M1: lin = LinW'(2 * ys - 1);
      L_2_M2Y: lin = LinW'(2 - 2 * ys);
      L_3_M2Y: lin = LinW'(3 - 2 * ys);
      default: lin = '0;
    endcase
  end

  // Shared multiplier operands
  always_comb begin
    case (uc.mul_a)
      MA_LIN:  mul_a = MulAW'(lin);
      MA_A2:   mul_a = signed'(MulAW'(a2_q));
      MA_B2:   mul_a = signed'(MulAW'(b2_q));
      MA_SQ:   mul_a = signed'(MulAW'(sq_q));
      default: mul_a = '0;
    endcase
    case (uc.mul_b)
      MB_LIN:  mul_b = MulBW'(lin);
      MB_A2:   mul_b = signed'(MulBW'(a2_q));
      MB_B2:   mul_b = signed'(MulBW'(b2_q));
      default: mul_b = '0;
    endcase
  end

  assign mul_full = mul_a * mul_b;

  // Accumulate into the decision variable or the scratch accumulator
  assign p_sh     = uc.sh2 ? (prod_q <<< 2) : prod_q;
  assign alu_base = (uc.dst == DST_ACC) ? acc_q : dec_q;

  always_comb begin
    case (uc.alu)
      ALU_LOAD: alu_res = p_sh;
      ALU_ADD:  alu_res = alu_base + p_sh;
      ALU_SUB:  alu_res = alu_base - p_sh;
      default:  alu_res = alu_base;
    endcase
  end

  // Pixel position for the current quadrant
  assign ox = PixW'(origin_x_q);
  assign oy = PixW'(origin_y_q);
  assign dx = signed'(PixW'(x_q));
  assign dy = signed'(PixW'(axis_b_q - y_q));

  always_comb begin
    case (uc.quad)
      Q_PP:    begin px = ox + dx; py = oy + dy; end
      Q_PM:    begin px = ox + dx; py = oy - dy; end
      Q_MM:    begin px = ox - dx; py = oy - dy; end
      Q_MP:    begin px = ox - dx; py = oy + dy; end
      default: begin px = ox;      py = oy;      end
    endcase
  end

  assign steps_inc = steps_q + 1'b1;

  // Next state
  always_comb begin
    busy_d     = busy_q;
    upc_d      = upc_q;
    active_d   = active_q;
    region_d   = region_q;
    origin_x_d = origin_x_q;
    origin_y_d = origin_y_q;
    axis_a_d   = axis_a_q;
    axis_b_d   = axis_b_q;
    x_d        = x_q;
    y_d        = y_q;
    steps_d    = steps_q;
    limit_d    = limit_q;
    mirror_d   = mirror_q;
    color_d    = color_q;
    a2_d       = a2_q;
    b2_d       = b2_q;
    sq_d       = sq_q;
    prod_d     = prod_q;
    dec_d      = dec_q;
    acc_d      = acc_q;

    if (!busy_q) begin
      if (in_accept) begin
        if (is_start) begin
          busy_d     = 1'b1;
          upc_d      = UA_S0;
          origin_x_d = center_x_i;
          origin_y_d = center_y_i;
          axis_a_d   = a_sat;
          axis_b_d   = b_sat;
          x_d        = '0;
          y_d        = b_sat;
          region_d   = 1'b0;
          steps_d    = '0;
          limit_d    = step_limit_i;
          mirror_d   = mirror_i;
          color_d    = color_i;
          active_d   = (b_sat != '0) && (step_limit_i != '0);
        end else if (active_q) begin
          busy_d = 1'b1;
          upc_d  = UA_P0;
        end
      end
    end else begin
      // Sequencer
      case (uc.seq)
        SEQ_NEXT:   upc_d = UAddrW'(upc_q + 1'b1);
        SEQ_BRANCH: upc_d = cond_true ? uc.target : UAddrW'(upc_q + 1'b1);
        SEQ_EMIT: begin
          if (slot_free) begin
            if (uc.last) begin
              busy_d = 1'b0;
            end else begin
              upc_d = UAddrW'(upc_q + 1'b1);
            end
          end
        end
        default: upc_d = upc_q;
      endcase

      // Datapath actions
      if (uc.mul_en) begin
        prod_d = mul_full[DecW-1:0];
      end
      case (uc.ld)
        LD_A2:   a2_d = prod_q[SqrW-1:0];
        LD_B2:   b2_d = prod_q[SqrW-1:0];
        LD_SQ:   sq_d = prod_q[SqW-1:0];
        default: ;
      endcase
      if (uc.alu != ALU_NONE) begin
        if (uc.dst == DST_ACC) begin
          acc_d = alu_res;
        end else begin
          dec_d = alu_res;
        end
      end
      if (uc.x_inc) begin
        x_d = x_q + 1'b1;
      end
      if (uc.y_dec) begin
        y_d = y_q - 1'b1;
      end
      if (uc.set_region) begin
        region_d = 1'b1;
      end
      if (uc.fin) begin
        steps_d = steps_inc;
        if ((y_q == '0) || (steps_inc >= limit_q)) begin
          active_d = 1'b0;
        end
      end
    end
  end

  // Output register
  always_comb begin
    out_valid_d = emit_fire | (out_valid_q & out_stall_i);
    px_d        = px_q;
    py_d        = py_q;
    pcol_d      = pcol_q;
    last_d      = last_q;
    done_d      = done_q;
    if (emit_fire) begin
      px_d   = px;
      py_d   = py;
      pcol_d = color_q;
      last_d = uc.last;
      done_d = uc.last & ~active_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      upc_q       <= UA_S0;
      active_q    <= 1'b0;
      region_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      upc_q       <= upc_d;
      active_q    <= active_d;
      region_q    <= region_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    origin_x_q <= origin_x_d;
    origin_y_q <= origin_y_d;
    axis_a_q   <= axis_a_d;
    axis_b_q   <= axis_b_d;
    x_q        <= x_d;
    y_q        <= y_d;
    steps_q    <= steps_d;
    limit_q    <= limit_d;
    mirror_q   <= mirror_d;
    color_q    <= color_d;
    a2_q       <= a2_d;
    b2_q       <= b2_d;
    sq_q       <= sq_d;
    prod_q     <= prod_d;
    dec_q      <= dec_d;
    acc_q      <= acc_d;
    px_q       <= px_d;
    py_q       <= py_d;
    pcol_q     <= pcol_d;
    last_q     <= last_d;
    done_q     <= done_d;
  end

  assign out_valid_o     = out_valid_q;
  assign pixel_x_o       = px_q;
  assign pixel_y_o       = py_q;
  assign pixel_color_o   = pcol_q;
  assign last_of_group_o = last_q;
  assign shape_done_o    = done_q;

endmodule
